[hw/rtl/bps_pkg.sv]
package bps_pkg;

   // Q2.14 unit length
   localparam int Q14_ONE   = 16384;
   // light direction (0, LIGHT_C, -LIGHT_C), normalize(0,1,-1) in Q2.14
   localparam int LIGHT_C   = 11585;
   // 0.2 in Q15
   localparam int AMB_Q15   = 6554;
   // 255 * 2 in Q15 scale for the Q2.14 specular power
   localparam int SPEC_Q15  = 510;

   // one result bit per stage of the root, one quotient bit per stage of the divide
   localparam int SQRT_STEPS = 30;
   localparam int DIV_STEPS  = 15;

   localparam int POS_W  = 24;
   localparam int NRM_W  = 16;
   localparam int TEX_W  = 8;
   // raw vector component into a normalizer: camera minus position
   localparam int VEC_W  = POS_W + 1;

   typedef logic signed [VEC_W-1:0] vec_type;
   typedef logic signed [15:0]      q14_type;
   typedef logic [TEX_W-1:0]        tex_type;

   typedef enum logic [1:0] {
      CSR_CAMERA_X = 2'd0,
      CSR_CAMERA_Y = 2'd1,
      CSR_CAMERA_Z = 2'd2
   } csr_index_type;

endpackage

[hw/rtl/bps_unit3.sv]
module bps_unit3 #(
   parameter int SIDE_W = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  bps_pkg::vec_type      v_in [3],
   input  logic [SIDE_W-1:0]     side_in,
   output logic                  out_valid,
   output bps_pkg::q14_type      u_out [3],
   output logic [SIDE_W-1:0]     side_out
);
   import bps_pkg::*;

   typedef struct packed {
      logic              valid;
      logic [SIDE_W-1:0] side;
      logic [2:0]        neg;
      logic              zero;
      logic [2:0][14:0]  m;
      logic [61:0]       x;
      logic [61:0]       r;
   } sq_type;

   typedef struct packed {
      logic              valid;
      logic [SIDE_W-1:0] side;
      logic [2:0]        neg;
      logic              zero;
      logic [29:0]       s;
      logic [2:0][44:0]  rem;
      logic [2:0][14:0]  q;
   } dv_type;

   // stage A: magnitudes
   logic              a_valid_ff;
   logic [SIDE_W-1:0] a_side_ff;
   logic [2:0]        a_neg_ff;
   logic [VEC_W-1:0]  a_m_ff [3];
   // stage B: largest magnitude
   logic              b_valid_ff;
   logic [SIDE_W-1:0] b_side_ff;
   logic [2:0]        b_neg_ff;
   logic [VEC_W-1:0]  b_m_ff [3];
   logic [VEC_W-1:0]  b_mx_ff;
   // stage C: leading one
   logic              c_valid_ff;
   logic [SIDE_W-1:0] c_side_ff;
   logic [2:0]        c_neg_ff;
   logic [VEC_W-1:0]  c_m_ff [3];
   logic [4:0]        c_msb_ff;
   logic              c_zero_ff;
   // stage D: scaled magnitudes
   logic              d_valid_ff;
   logic [SIDE_W-1:0] d_side_ff;
   logic [2:0]        d_neg_ff;
   logic [2:0][14:0]  d_m_ff;
   logic              d_zero_ff;

   sq_type sq_ff [SQRT_STEPS+1];
   dv_type dv_ff [DIV_STEPS+1];

   function automatic logic [4:0] msb_of(input logic [VEC_W-1:0] v);
      logic [4:0] p;
      p = '0;
      for (int i = 0; i < VEC_W; i++) begin
         if (v[i]) p = 5'(i);
      end
      return p;
   endfunction

   function automatic sq_type sqrt_step(input sq_type s, input int k);
      sq_type     o;
      logic [61:0] b;
      logic [61:0] t;
      o = s;
      b = 62'(1) << (2 * (SQRT_STEPS - 1 - k));
      t = s.r + b;
      if (s.x >= t) begin
         o.x = s.x - t;
         o.r = (s.r >> 1) + b;
      end else begin
         o.r = s.r >> 1;
      end
      return o;
   endfunction

   function automatic dv_type div_step(input dv_type s, input int j);
      dv_type      o;
      logic [44:0] d;
      o = s;
      d = 45'(s.s) << (DIV_STEPS - 1 - j);
      for (int c = 0; c < 3; c++) begin
         if (s.rem[c] >= d) begin
            o.rem[c] = s.rem[c] - d;
            o.q[c][DIV_STEPS-1-j] = 1'b1;
         end
      end
      return o;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         for (int k = 0; k <= SQRT_STEPS; k++) sq_ff[k].valid <= 1'b0;
         for (int j = 0; j <= DIV_STEPS; j++) dv_ff[j].valid <= 1'b0;
      end else begin
         // A
         a_valid_ff <= in_valid;
         a_side_ff  <= side_in;
         for (int c = 0; c < 3; c++) begin
            a_neg_ff[c] <= v_in[c][VEC_W-1];
            a_m_ff[c]   <= v_in[c][VEC_W-1] ? VEC_W'(-v_in[c]) : VEC_W'(v_in[c]);
         end
         // B
         b_valid_ff <= a_valid_ff;
         b_side_ff  <= a_side_ff;
         b_neg_ff   <= a_neg_ff;
         b_m_ff     <= a_m_ff;
         if (a_m_ff[0] >= a_m_ff[1] && a_m_ff[0] >= a_m_ff[2]) b_mx_ff <= a_m_ff[0];
         else if (a_m_ff[1] >= a_m_ff[2])                      b_mx_ff <= a_m_ff[1];
         else                                                  b_mx_ff <= a_m_ff[2];
         // C
         c_valid_ff <= b_valid_ff;
         c_side_ff  <= b_side_ff;
         c_neg_ff   <= b_neg_ff;
         c_m_ff     <= b_m_ff;
         c_msb_ff   <= msb_of(b_mx_ff);
         c_zero_ff  <= (b_mx_ff == '0);
         // D: bring the leading one of the largest to bit 14
         d_valid_ff <= c_valid_ff;
         d_side_ff  <= c_side_ff;
         d_neg_ff   <= c_neg_ff;
         d_zero_ff  <= c_zero_ff;
         for (int c = 0; c < 3; c++) begin
            if (c_msb_ff >= 5'd14) d_m_ff[c] <= 15'(c_m_ff[c] >> (c_msb_ff - 5'd14));
            else                   d_m_ff[c] <= 15'(c_m_ff[c] << (5'd14 - c_msb_ff));
         end
         // E: squared length, scaled by 2^28 for the root
         sq_ff[0].valid <= d_valid_ff;
         sq_ff[0].side  <= d_side_ff;
         sq_ff[0].neg   <= d_neg_ff;
         sq_ff[0].zero  <= d_zero_ff;
         sq_ff[0].m     <= d_m_ff;
         sq_ff[0].r     <= '0;
         sq_ff[0].x     <= {2'b00, 32'(d_m_ff[0] * d_m_ff[0]) + 32'(d_m_ff[1] * d_m_ff[1])
                            + 32'(d_m_ff[2] * d_m_ff[2]), 28'b0};
         for (int k = 0; k < SQRT_STEPS; k++) sq_ff[k+1] <= sqrt_step(sq_ff[k], k);
         // divide setup
         dv_ff[0].valid <= sq_ff[SQRT_STEPS].valid;
         dv_ff[0].side  <= sq_ff[SQRT_STEPS].side;
         dv_ff[0].neg   <= sq_ff[SQRT_STEPS].neg;
         dv_ff[0].zero  <= sq_ff[SQRT_STEPS].zero;
         dv_ff[0].s     <= sq_ff[SQRT_STEPS].r[29:0];
         dv_ff[0].q     <= '0;
         for (int c = 0; c < 3; c++) dv_ff[0].rem[c] <= {2'b00, sq_ff[SQRT_STEPS].m[c], 28'b0};
         for (int j = 0; j < DIV_STEPS; j++) dv_ff[j+1] <= div_step(dv_ff[j], j);
      end
   end

   always_comb begin
      out_valid = dv_ff[DIV_STEPS].valid;
      side_out  = dv_ff[DIV_STEPS].side;
      for (int c = 0; c < 3; c++) begin
         if (dv_ff[DIV_STEPS].zero)        u_out[c] = '0;
         else if (dv_ff[DIV_STEPS].neg[c]) u_out[c] = -q14_type'({1'b0, dv_ff[DIV_STEPS].q[c]});
         else                              u_out[c] = q14_type'({1'b0, dv_ff[DIV_STEPS].q[c]});
      end
   end

endmodule

[hw/rtl/bps_shade.sv]
module bps_shade (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  bps_pkg::q14_type n_in [3],
   input  bps_pkg::q14_type h_in [3],
   input  bps_pkg::tex_type tex_in [3],
   output logic             out_valid,
   output bps_pkg::tex_type color_out [3],
   output logic             sat_out
);
   import bps_pkg::*;

   logic              v_ff [7];
   logic signed [15:0] d_ff [7];
   logic [14:0]       p_ff [7];
   logic [14:0]       acc_ff [7];
   tex_type           t_ff [7][3];

   logic signed [33:0] nh;
   logic signed [33:0] nl;
   logic signed [33:0] nh_r;
   logic signed [33:0] nl_r;
   logic [14:0]        p_clip;

   logic              out_valid_ff;
   tex_type           color_ff [3];
   logic              sat_ff;
   tex_type           color_in [3];
   logic              sat_in;

   function automatic logic [14:0] qmul(input logic [14:0] a, input logic [14:0] b);
      logic [30:0] pr;
      pr = 31'(a * b) + 31'(Q14_ONE / 2);
      return pr[28:14];
   endfunction

   always_comb begin
      nh = 34'(n_in[0] * h_in[0]) + 34'(n_in[1] * h_in[1]) + 34'(n_in[2] * h_in[2]);
      nl = 34'(n_in[1] * 16'sd11585) - 34'(n_in[2] * 16'sd11585);
      nh_r = (nh + 34'sd8192) >>> 14;
      nl_r = (nl + 34'sd8192) >>> 14;
      if (nh_r < 0)                      p_clip = '0;
      else if (nh_r > 34'(Q14_ONE))      p_clip = 15'(Q14_ONE);
      else                               p_clip = nh_r[14:0];
   end

   // channel sum in Q15 and saturation
   always_comb begin
      logic signed [27:0] ts;
      logic signed [27:0] ds;
      logic signed [27:0] ps;
      logic signed [27:0] sum;
      logic signed [12:0] c;
      sat_in = 1'b0;
      ds = 28'(d_ff[6]);
      ps = 28'({13'b0, acc_ff[6]});
      for (int k = 0; k < 3; k++) begin
         ts  = 28'({20'b0, t_ff[6][k]});
         sum = ts * 28'(AMB_Q15) + ts * ds + ps * 28'(SPEC_Q15) + 28'sd16384;
         c   = 13'(sum >>> 15);
         if (c < 0) begin
            color_in[k] = '0;
            sat_in = 1'b1;
         end else if (c > 13'sd255) begin
            color_in[k] = 8'hFF;
            sat_in = 1'b1;
         end else begin
            color_in[k] = c[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 7; s++) v_ff[s] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         // dot products
         v_ff[0]   <= in_valid;
         d_ff[0]   <= nl_r[15:0];
         p_ff[0]   <= p_clip;
         acc_ff[0] <= p_clip;
         t_ff[0]   <= tex_in;
         for (int s = 1; s < 7; s++) begin
            v_ff[s] <= v_ff[s-1];
            d_ff[s] <= d_ff[s-1];
            p_ff[s] <= p_ff[s-1];
            t_ff[s] <= t_ff[s-1];
         end
         // power chain p2, p4, p5, p10, p20
         acc_ff[1] <= qmul(acc_ff[0], acc_ff[0]);
         acc_ff[2] <= qmul(acc_ff[1], acc_ff[1]);
         acc_ff[3] <= qmul(acc_ff[2], p_ff[2]);
         acc_ff[4] <= qmul(acc_ff[3], acc_ff[3]);
         acc_ff[5] <= qmul(acc_ff[4], acc_ff[4]);
         acc_ff[6] <= acc_ff[5];
         out_valid_ff <= v_ff[6];
         color_ff     <= color_in;
         sat_ff       <= sat_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign color_out = color_ff;
   assign sat_out   = sat_ff;

endmodule

[hw/rtl/blinn_phong_fragment_shade_unit.sv]
// Blinn-Phong fragment shader. One fragment transaction is taken per clock:
// busy never rises, so start may be held high every cycle. Each transaction
// yields exactly one result, shown for one cycle with rsp_valid high, in
// order; the receiver cannot stall. The latency is set mainly by the two
// normalizers in series (view, then half vector), each a 30-stage
// bit-per-stage square root followed by a 15-stage bit-per-stage divide.
// Camera registers are written through the csr_ channel (always ready) and
// should change only while no fragment is in flight.
module blinn_phong_fragment_shade_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [15:0]            req_normal_x,
   input  logic signed [15:0]            req_normal_y,
   input  logic signed [15:0]            req_normal_z,
   input  logic signed [23:0]            req_pos_x,
   input  logic signed [23:0]            req_pos_y,
   input  logic signed [23:0]            req_pos_z,
   input  logic [7:0]                    req_tex_r,
   input  logic [7:0]                    req_tex_g,
   input  logic [7:0]                    req_tex_b,
   output logic                          rsp_valid,
   output logic [7:0]                    rsp_red,
   output logic [7:0]                    rsp_green,
   output logic [7:0]                    rsp_blue,
   output logic                          rsp_saturated,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [23:0]                   csr_data
);
   import bps_pkg::*;

   // camera position, Q16.8
   logic signed [POS_W-1:0] cam_ff [3];

   // input stage
   logic    in_valid_ff;
   vec_type nrm_ff [3];
   vec_type view_ff [3];
   tex_type tex_ff [3];

   // normalizer outputs
   logic    n_valid;
   q14_type n_unit [3];
   logic [2*TEX_W-1:0] n_side;
   logic    v_valid;
   q14_type v_unit [3];
   logic [TEX_W-1:0] v_side;

   // half vector before normalizing
   vec_type half_vec [3];
   logic [3*16+3*TEX_W-1:0] h_side_in;
   logic    h_valid;
   q14_type h_unit [3];
   logic [3*16+3*TEX_W-1:0] h_side;

   q14_type n_dly [3];
   tex_type tex_dly [3];
   tex_type color [3];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 3; c++) cam_ff[c] <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CAMERA_X: cam_ff[0] <= csr_data;
            CSR_CAMERA_Y: cam_ff[1] <= csr_data;
            CSR_CAMERA_Z: cam_ff[2] <= csr_data;
            default: ;   // unknown index: write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
         nrm_ff[0]  <= VEC_W'(req_normal_x);
         nrm_ff[1]  <= VEC_W'(req_normal_y);
         nrm_ff[2]  <= VEC_W'(req_normal_z);
         view_ff[0] <= VEC_W'(cam_ff[0]) - VEC_W'(req_pos_x);
         view_ff[1] <= VEC_W'(cam_ff[1]) - VEC_W'(req_pos_y);
         view_ff[2] <= VEC_W'(cam_ff[2]) - VEC_W'(req_pos_z);
         tex_ff[0]  <= req_tex_r;
         tex_ff[1]  <= req_tex_g;
         tex_ff[2]  <= req_tex_b;
      end
   end

   // normal and view vectors normalize side by side; the texel rides along,
   // red and green with the normal, blue with the view vector
   bps_unit3 #(.SIDE_W(2*TEX_W)) u_norm_n (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid_ff),
      .v_in     (nrm_ff),
      .side_in  ({tex_ff[0], tex_ff[1]}),
      .out_valid(n_valid),
      .u_out    (n_unit),
      .side_out (n_side)
   );

   bps_unit3 #(.SIDE_W(TEX_W)) u_norm_v (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid_ff),
      .v_in     (view_ff),
      .side_in  (tex_ff[2]),
      .out_valid(v_valid),
      .u_out    (v_unit),
      .side_out (v_side)
   );

   // half vector = light + view, light = (0, LIGHT_C, -LIGHT_C)
   always_comb begin
      half_vec[0] = VEC_W'(v_unit[0]);
      half_vec[1] = VEC_W'(v_unit[1]) + VEC_W'(LIGHT_C);
      half_vec[2] = VEC_W'(v_unit[2]) - VEC_W'(LIGHT_C);
      h_side_in   = {n_unit[0], n_unit[1], n_unit[2], n_side, v_side};
   end

   bps_unit3 #(.SIDE_W(3*16+3*TEX_W)) u_norm_h (
      .clock    (clock),
      .reset    (reset),
      .in_valid (n_valid && v_valid),
      .v_in     (half_vec),
      .side_in  (h_side_in),
      .out_valid(h_valid),
      .u_out    (h_unit),
      .side_out (h_side)
   );

   always_comb begin
      n_dly[0]   = h_side[71:56];
      n_dly[1]   = h_side[55:40];
      n_dly[2]   = h_side[39:24];
      tex_dly[0] = h_side[23:16];
      tex_dly[1] = h_side[15:8];
      tex_dly[2] = h_side[7:0];
   end

   bps_shade u_shade (
      .clock    (clock),
      .reset    (reset),
      .in_valid (h_valid),
      .n_in     (n_dly),
      .h_in     (h_unit),
      .tex_in   (tex_dly),
      .out_valid(rsp_valid),
      .color_out(color),
      .sat_out  (rsp_saturated)
   );

   assign rsp_red   = color[0];
   assign rsp_green = color[1];
   assign rsp_blue  = color[2];

endmodule
